>>> sv/hcbp_pkg.sv
// Package for the Huffman code bit packer.
// Holds command codes, field widths and the types shared by the front end,
// the queue and the packer. No dependencies.
`default_nettype none

package hcbp_pkg;

  // Field widths fixed by the item format
  localparam int unsigned CmdW  = 2;
  localparam int unsigned SymW  = 8;
  localparam int unsigned CodeW = 8;
  localparam int unsigned LenW  = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 3;

  // Command codes
  localparam logic [CmdW-1:0] CmdLoad   = 2'd0;
  localparam logic [CmdW-1:0] CmdEncode = 2'd1;
  localparam logic [CmdW-1:0] CmdFlush  = 2'd2;

  // One code table entry
  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [CodeW-1:0] code;
  } hcbp_entry_t;

  // One classified request passed from the front end to the packer
  typedef struct packed {
    logic             flush;
    logic [LenW-1:0]  len;
    logic [CodeW-1:0] code;
  } hcbp_op_t;

endpackage

`default_nettype wire

>>> sv/hcbp_if.sv
// Channel interfaces of the Huffman code bit packer: the request channel
// and the packed byte channel. Depends on hcbp_pkg.
`default_nettype none

interface hcbp_in_if
  import hcbp_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [SymW-1:0] symbol;
  logic [CodeW-1:0] code_bits;
  logic [LenW-1:0] code_length;

  modport source (output valid, command, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, command, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_out_if
  import hcbp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic [ByteW-1:0] pad_mask;
  logic             is_last;

  modport source (output valid, out_byte, pad_mask, is_last, input ready);
  modport sink   (input valid, out_byte, pad_mask, is_last, output ready);
endinterface

`default_nettype wire

>>> sv/hcbp_front.sv
// Front end of the bit packer: accepts requests, writes and reads the code
// table, and hands encode and flush requests to the queue.
// Depends on hcbp_pkg and hcbp_in_if.
`default_nettype none

module hcbp_front
  import hcbp_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned MAX_CODE_LEN = 8,
  parameter int unsigned QUEUE_DEPTH  = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  hcbp_in_if.sink          in_i,
  input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] level_i,
  output logic             push_o,
  output hcbp_op_t         op_o
);

  localparam int unsigned AddrW = $clog2(SYMBOL_COUNT);
  localparam int unsigned LvlW  = $clog2(QUEUE_DEPTH + 1);

  hcbp_entry_t table_mem [SYMBOL_COUNT];
  hcbp_entry_t rd_q;
  hcbp_entry_t wr_entry;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_flush_q;
  logic             accept;
  logic             in_range;
  logic             wr_en;
  logic             rd_en;
  logic [AddrW-1:0] addr;
  logic [LenW-1:0]  len_clamped;
  logic [CodeW:0]   len_mask;

  // Hold off new requests unless the queue has room for everything in flight
  assign in_i.ready = (({1'b0, level_i} + (LvlW+1)'(s1_valid_q))
                       < (LvlW+1)'(QUEUE_DEPTH));
  assign accept     = in_i.valid && in_i.ready;

  // Classify the request
  assign in_range = ({1'b0, in_i.symbol} < (SymW+1)'(SYMBOL_COUNT));
  assign addr     = in_i.symbol[AddrW-1:0];
  assign wr_en    = accept && (in_i.command == CmdLoad) && in_range;
  assign rd_en    = accept && (in_i.command == CmdEncode) && in_range;

  // Clamp the length and strip stray codeword bits
  assign len_clamped = (in_i.code_length > LenW'(MAX_CODE_LEN))
                       ? LenW'(MAX_CODE_LEN) : in_i.code_length;
  assign len_mask    = ((CodeW+1)'(1) << len_clamped) - (CodeW+1)'(1);
  assign wr_entry.len  = len_clamped;
  assign wr_entry.code = in_i.code_bits & len_mask[CodeW-1:0];

  // Code table with a registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= table_mem[addr];
    end
  end

  // Track the request whose table read is in flight
  assign s1_valid_d = rd_en || (accept && (in_i.command == CmdFlush));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flush_q <= (in_i.command == CmdFlush);
    end
  end

  // Hand the classified request to the queue
  assign push_o     = s1_valid_q;
  assign op_o.flush = s1_flush_q;
  assign op_o.len   = rd_q.len;
  assign op_o.code  = rd_q.code;

endmodule

`default_nettype wire

>>> sv/hcbp_queue.sv
// Short request queue between the front end and the packer.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_queue
  import hcbp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire hcbp_op_t  data_i,
  input  wire logic      pop_i,
  output hcbp_op_t       data_o,
  output logic           valid_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LvlW = $clog2(DEPTH + 1);

  hcbp_op_t        slots_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [LvlW-1:0] level_q;
  logic            do_pop;

  assign do_pop  = pop_i && (level_q != '0);
  assign valid_o = (level_q != '0);
  assign data_o  = slots_q[rd_ptr_q];
  assign level_o = level_q;

  // Store pushed requests
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and the fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !do_pop) begin
        level_q <= level_q + LvlW'(1);
      end else if (!push_i && do_pop) begin
        level_q <= level_q - LvlW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/hcbp_back.sv
// Packer back end: appends codewords to the byte accumulator, emits full
// bytes and the padded final byte into an output register.
// Depends on hcbp_pkg and hcbp_out_if.
`default_nettype none

module hcbp_back
  import hcbp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire hcbp_op_t op_i,
  input  wire logic     op_valid_i,
  output logic          pop_o,
  hcbp_out_if.source    out_o
);

  logic [ByteW-1:0] bits_q, bits_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             out_valid_q;
  logic [ByteW-1:0] byte_q, mask_q;
  logic             last_q;

  logic             take;
  logic             has_result;
  logic [ByteW-1:0] res_byte, res_mask;
  logic [LenW-1:0]  total, spill;
  logic [ByteW-1:0] shifted;
  logic [ByteW-1:0] merged, head, spill_mask;

  // Take a request when the output register is free or being drained
  assign take  = op_valid_i && (!out_valid_q || out_o.ready);
  assign pop_o = take;

  // Shift-or datapath
  assign total      = LenW'(cnt_q) + op_i.len;
  assign spill      = total - LenW'(ByteW);
  assign shifted    = bits_q << op_i.len;
  assign merged     = shifted | op_i.code;
  assign head       = bits_q << (LenW'(ByteW) - LenW'(cnt_q));
  assign spill_mask = (ByteW'(1) << spill) - ByteW'(1);

  always_comb begin
    bits_d     = bits_q;
    cnt_d      = cnt_q;
    has_result = 1'b0;
    res_byte   = head;
    res_mask   = '0;
    if (op_i.flush) begin
      // Pad and close the stream
      has_result = 1'b1;
      res_mask   = 8'hFF >> cnt_q;
      bits_d     = '0;
      cnt_d      = '0;
    end else if (op_i.len == '0) begin
      // Empty codeword: nothing to append
    end else if (total < LenW'(ByteW)) begin
      bits_d = merged;
      cnt_d  = total[CntW-1:0];
    end else if (total == LenW'(ByteW)) begin
      has_result = 1'b1;
      res_byte   = merged;
      bits_d     = '0;
      cnt_d      = '0;
    end else begin
      // Codeword crosses the byte boundary: keep the low spill bits
      has_result = 1'b1;
      res_byte   = head | (op_i.code >> spill);
      bits_d     = op_i.code & spill_mask;
      cnt_d      = spill[CntW-1:0];
    end
  end

  // Accumulator and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        bits_q <= bits_d;
        cnt_q  <= cnt_d;
      end
      if (take && has_result) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (take && has_result) begin
      byte_q <= res_byte;
      mask_q <= res_mask;
      last_q <= op_i.flush;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.pad_mask = mask_q;
  assign out_o.is_last  = last_q;

endmodule

`default_nettype wire

>>> sv/huffman_code_bit_packer.sv
// Huffman code bit packer, top level.
// Request channel in_i (sink): command, symbol, code_bits, code_length.
//   Load writes a code table entry, encode appends the symbol's codeword
//   MSB first, flush pads and emits the final byte with its pad mask.
// Result channel out_o (source): out_byte, pad_mask, is_last.
// Throughput: one request per cycle while in_i.ready is high, set by the single-port code table
//   (one write or one registered read per cycle) and the registered
//   shift-or update of the byte accumulator.
// A result passes from the table read register, loaded at the edge that accepts
//   its request, to a queue slot and then to the output register.
// Reset clears the accumulator, the queue and the output valid flag. The code
//   table is not cleared; each entry must be loaded before it is encoded.
// When the receiver stalls, the output register holds its byte, requests
//   collect in the queue, and in_i.ready falls once the queue slots and the
//   table read in flight are all taken.
// Depends on hcbp_pkg, hcbp_if, hcbp_front, hcbp_queue and hcbp_back.
`default_nettype none

module huffman_code_bit_packer
  import hcbp_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned MAX_CODE_LEN = 8,
  parameter int unsigned QUEUE_DEPTH  = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hcbp_in_if.sink    in_i,
  hcbp_out_if.source out_o
);

  localparam int unsigned LvlW = $clog2(QUEUE_DEPTH + 1);

  logic            push;
  hcbp_op_t        push_op;
  hcbp_op_t        head_op;
  logic            head_valid;
  logic            pop;
  logic [LvlW-1:0] level;

  // Accept and classify requests, look up codewords
  hcbp_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .level_i (level),
    .push_o  (push),
    .op_o    (push_op)
  );

  // Decouple the front end from the packer
  hcbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .pop_i   (pop),
    .data_o  (head_op),
    .valid_o (head_valid),
    .level_o (level)
  );

  // Pack codewords into bytes
  hcbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (head_op),
    .op_valid_i (head_valid),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

>>> test/tb_huffman_code_bit_packer.sv
// Testbench for huffman_code_bit_packer: directed and random requests on the
// request channel, every packed byte checked against an in-bench predictor.
// Depends on hcbp_pkg, hcbp_if and the packer RTL.

module tb_huffman_code_bit_packer;
  import hcbp_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int unsigned TableDepth    = 256;
  localparam int unsigned MaxLen        = 8;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned TailCycles    = 20;
  localparam int unsigned ItemsPerPhase = 160;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [ByteW-1:0] pad_mask;
    logic             is_last;
  } packed_byte_t;

  // Predicts the packed byte stream and checks the bytes that come out
  class byte_stream_predictor;
    hcbp_entry_t      code_table [TableDepth];
    logic [ByteW-1:0] pend_bits;
    logic [CntW-1:0]  pend_cnt;
    packed_byte_t     expected_bytes [$];
    int unsigned      errors;

    function new();
      pend_bits = '0;
      pend_cnt  = '0;
      errors    = 0;
      foreach (code_table[i]) code_table[i] = '0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void push_byte(int unsigned b, int unsigned m, bit last);
      packed_byte_t e;
      e.out_byte = b[ByteW-1:0];
      e.pad_mask = m[ByteW-1:0];
      e.is_last  = last;
      expected_bytes.push_back(e);
    endfunction

    // Update the accumulator for one accepted request
    function void note_request(logic [CmdW-1:0] cmd, logic [SymW-1:0] sym,
                               logic [CodeW-1:0] bits, logic [LenW-1:0] len);
      int unsigned cl, cw, cnt, acc, total, spill;
      cnt = pend_cnt;
      acc = pend_bits;
      case (cmd)
        CmdLoad: begin
          cl = len;
          if (cl > MaxLen) cl = MaxLen;
          cw = bits & ((32'd1 << cl) - 1);
          code_table[sym].len  = cl[LenW-1:0];
          code_table[sym].code = cw[CodeW-1:0];
        end
        CmdEncode: begin
          cl    = code_table[sym].len;
          cw    = code_table[sym].code;
          total = cnt + cl;
          if (cl == 0) begin
            // zero-length codeword: nothing appended
          end else if (total < 8) begin
            pend_bits = ByteW'((acc << cl) | cw);
            pend_cnt  = CntW'(total);
          end else if (total == 8) begin
            push_byte((acc << cl) | cw, 0, 1'b0);
            pend_bits = '0;
            pend_cnt  = '0;
          end else begin
            // split codeword: high part completes the byte, spill bits stay
            spill = total - 8;
            push_byte((acc << (8 - cnt)) | (cw >> spill), 0, 1'b0);
            pend_bits = ByteW'(cw & ((32'd1 << spill) - 1));
            pend_cnt  = CntW'(spill);
          end
        end
        CmdFlush: begin
          push_byte(acc << (8 - cnt), 8'hFF >> cnt, 1'b1);
          pend_bits = '0;
          pend_cnt  = '0;
        end
        default: begin
        end
      endcase
    endfunction

    // Compare one accepted byte with the oldest prediction
    function void check_result(logic [ByteW-1:0] b, logic [ByteW-1:0] m, logic last);
      packed_byte_t e;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: out_byte %02h pad_mask %02h is_last %0b", b, m, last);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      if (b !== e.out_byte) begin
        $error("out_byte: expected %02h, actual %02h", e.out_byte, b);
        errors++;
      end
      if (m !== e.pad_mask) begin
        $error("pad_mask: expected %02h, actual %02h", e.pad_mask, m);
        errors++;
      end
      if (last !== e.is_last) begin
        $error("is_last: expected %0b, actual %0b", e.is_last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          sym_loaded [TableDepth];
  int          loaded_syms [$];

  byte_stream_predictor sb = new();

  hcbp_in_if  req_if ();
  hcbp_out_if byte_if ();

  huffman_code_bit_packer u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (byte_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Note accepted requests and check accepted bytes
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.command, req_if.symbol, req_if.code_bits, req_if.code_length);
      if (byte_if.valid && byte_if.ready)
        sb.check_result(byte_if.out_byte, byte_if.pad_mask, byte_if.is_last);
    end
  end

  // Receiver: random stalls, or a long hold-off when asked
  initial begin
    byte_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        byte_if.ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        byte_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (byte_if.valid && byte_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_huffman_code_bit_packer: errors");
    $finish;
  end

  // Offer one request, idling first at random; entered and left at a falling edge
  task automatic send_request(input logic [CmdW-1:0] cmd, input logic [SymW-1:0] sym,
                              input logic [CodeW-1:0] bits, input logic [LenW-1:0] len);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.command     = cmd;
    req_if.symbol      = sym;
    req_if.code_bits   = bits;
    req_if.code_length = len;
    req_if.valid       = 1'b1;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic load_entry(input logic [SymW-1:0] sym, input logic [CodeW-1:0] bits,
                            input logic [LenW-1:0] len);
    send_request(CmdLoad, sym, bits, len);
    if (!sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  task automatic encode_symbol(input logic [SymW-1:0] sym);
    send_request(CmdEncode, sym, CodeW'($urandom), LenW'($urandom));
  endtask

  task automatic flush_stream();
    send_request(CmdFlush, SymW'($urandom), CodeW'($urandom), LenW'($urandom));
  endtask

  // Hold the request side until every predicted byte has arrived
  task automatic drain_results();
    req_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Mostly encodes of loaded symbols, with reloads, flushes and a little noise
  task automatic send_random_item();
    int unsigned pick, len;
    pick = $urandom_range(0, 99);
    if (pick < 15 || loaded_syms.size() == 0) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 15);
      else len = $urandom_range(1, MaxLen);
      load_entry(SymW'($urandom), CodeW'($urandom), LenW'(len));
    end else if (pick < 85) begin
      encode_symbol(SymW'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]));
    end else if (pick < 96) begin
      flush_stream();
    end else begin
      send_request(CmdUnused, SymW'($urandom), CodeW'($urandom), LenW'($urandom));
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.command     = CmdLoad;
    req_if.symbol      = '0;
    req_if.code_bits   = '0;
    req_if.code_length = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: table extremes, clamped length, stray bits, zero length
    load_entry(8'd0,   8'h01, 4'd1);
    load_entry(8'd255, 8'hFF, 4'd8);
    load_entry(8'd1,   8'hA5, 4'd15);
    load_entry(8'd2,   8'hFF, 4'd3);
    load_entry(8'd3,   8'h55, 4'd0);
    load_entry(8'd4,   8'h00, 4'd7);
    load_entry(8'd5,   8'h0F, 4'd9);
    // flush with nothing pending, then an exact byte and a zero-length code
    flush_stream();
    encode_symbol(8'd255);
    encode_symbol(8'd3);
    // split codewords across byte boundaries, then a partial flush
    encode_symbol(8'd0);
    encode_symbol(8'd255);
    encode_symbol(8'd2);
    encode_symbol(8'd4);
    flush_stream();
    encode_symbol(8'd4);
    encode_symbol(8'd0);
    encode_symbol(8'd1);
    encode_symbol(8'd5);
    flush_stream();
    send_request(CmdUnused, 8'hFF, 8'hFF, 4'hF);
    flush_stream();
    encode_symbol(8'd0);
    flush_stream();
    drain_results();

    // Random phases with different idling on each side
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (phase == 0 && i == 50) hold_req = 1'b1;
        if (phase == 1 && i == 80) drain_results();
        send_random_item();
      end
      drain_results();
    end

    repeat (TailCycles) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_huffman_code_bit_packer: clean");
    end else begin
      $display("tb_huffman_code_bit_packer: errors");
    end
    $finish;
  end

endmodule
